// ===== rtl/core/set_assoc_write_through_cache_defines.svh =====
// assertion helpers used by the cache back end
`ifndef SET_ASSOC_WRITE_THROUGH_CACHE_DEFINES_SVH
`define SET_ASSOC_WRITE_THROUGH_CACHE_DEFINES_SVH

// condition implies consequence in the same cycle
`define SAWTC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define SAWTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sawtc_pkg.sv =====
package sawtc_pkg;

    // default geometry
    localparam int NUM_SETS_DEF  = 8;
    localparam int LINE_SIZE_DEF = 64;
    localparam int NUM_WAYS_DEF  = 128;
    localparam int ADDR_BITS_DEF = 20;
    localparam int AGE_BITS_DEF  = 16;

    // field widths
    localparam int ADDR_W    = 20;
    localparam int LEN_W     = 3;
    localparam int DATA_W    = 32;
    localparam int CNT_W     = 3;
    localparam int OP_ADDR_W = 32;
    localparam int LANE_W    = 2;

    // lookup queue depth
    localparam int OPQ_DEPTH = 4;

    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic [LEN_W-1:0] MAX_LEN = 3'd4;

    // one line lookup handed from front to back
    typedef struct packed {
        logic                 wr;
        logic [OP_ADDR_W-1:0] addr;
        logic [LEN_W-1:0]     nbytes;
        logic [LANE_W-1:0]    lane;
        logic [DATA_W-1:0]    wdata;
        logic [CNT_W-1:0]     lookups;
        logic                 last;
    } op_t;

    typedef enum logic [3:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_SCAN,
        BK_SCAN_TAIL,
        BK_DECIDE,
        BK_DATA_RD,
        BK_DATA_WR,
        BK_UPDATE,
        BK_UPD_TAIL,
        BK_FINISH
    } bk_state_t;

endpackage

// ===== rtl/core/sawtc_req_if.sv =====
interface sawtc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [sawtc_pkg::ADDR_W-1:0]  address;
    logic [sawtc_pkg::LEN_W-1:0]   length;
    logic [sawtc_pkg::DATA_W-1:0]  write_data;

    modport source (output valid, req_type, address, length, write_data, input ready);
    modport sink (input valid, req_type, address, length, write_data, output ready);
endinterface

// ===== rtl/core/sawtc_rsp_if.sv =====
interface sawtc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [sawtc_pkg::DATA_W-1:0]  read_data;
    logic [sawtc_pkg::CNT_W-1:0]   lookups;
    logic [sawtc_pkg::CNT_W-1:0]   hit_count;

    modport source (output valid, read_data, lookups, hit_count, input ready);
    modport sink (input valid, read_data, lookups, hit_count, output ready);
endinterface

// ===== rtl/core/sawtc_front.sv =====
module sawtc_front #(
    parameter int ADDR_BITS = sawtc_pkg::ADDR_BITS_DEF,
    parameter int LINE_SIZE = sawtc_pkg::LINE_SIZE_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    sawtc_req_if.sink         req,
    input  logic              init_done,
    output sawtc_pkg::op_t    op,
    output logic              op_push,
    input  logic              op_full
);
    import sawtc_pkg::*;

    localparam int OFF_LOG = $clog2(LINE_SIZE);
    localparam int SUM_W   = OFF_LOG + 2;

    logic                  busy_reg, busy_next;
    logic                  wr_reg;
    logic [ADDR_BITS-1:0]  addr_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [DATA_W-1:0]     wdata_reg;
    logic                  split_reg;
    logic [LANE_W-1:0]     idx_reg, idx_next;

    logic                  accept;
    logic [LEN_W-1:0]      len_eff;
    logic [ADDR_BITS-1:0]  addr_in;
    logic [SUM_W-1:0]      end_pos;
    logic                  split_in;
    logic                  last_piece;

    assign req.ready = init_done && !busy_reg;
    assign accept    = req.valid && req.ready;

    // classify the incoming request
    assign len_eff  = (req.length > MAX_LEN) ? MAX_LEN : req.length;
    assign addr_in  = ADDR_BITS'(req.address);
    assign end_pos  = SUM_W'(addr_in[OFF_LOG-1:0]) + SUM_W'(len_eff);
    assign split_in = end_pos > SUM_W'(LINE_SIZE);

    assign last_piece = !split_reg || ({1'b0, idx_reg} == len_reg - 3'd1);

    // lookup generation
    always_comb
    begin
        op.wr = wr_reg;
        if (split_reg)
        begin
            op.addr    = OP_ADDR_W'(addr_reg + ADDR_BITS'(idx_reg));
            op.nbytes  = 3'd1;
            op.lane    = idx_reg;
            op.wdata   = (wdata_reg >> {idx_reg, 3'b000}) & 32'hFF;
            op.lookups = len_reg;
        end
        else
        begin
            op.addr    = OP_ADDR_W'(addr_reg);
            op.nbytes  = len_reg;
            op.lane    = '0;
            op.wdata   = wdata_reg;
            op.lookups = 3'd1;
        end
        op.last = last_piece;
    end

    assign op_push = busy_reg && !op_full;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (accept)
        begin
            busy_next = 1'b1;
            idx_next  = '0;
        end
        else if (op_push)
        begin
            if (last_piece)
                busy_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wr_reg    <= req.req_type;
            addr_reg  <= addr_in;
            len_reg   <= len_eff;
            wdata_reg <= req.write_data;
            split_reg <= split_in;
        end
    end

endmodule

// ===== rtl/core/sawtc_op_fifo.sv =====
module sawtc_op_fifo #(
    parameter int DEPTH = sawtc_pkg::OPQ_DEPTH
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  sawtc_pkg::op_t  din,
    output logic            full,
    input  logic            pop,
    output sawtc_pkg::op_t  dout,
    output logic            empty
);
    import sawtc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    op_t                 slot_reg [DEPTH];
    logic [PTR_W-1:0]    wptr_reg, rptr_reg;
    logic [CNT_BITS-1:0] count_reg;
    logic                do_push, do_pop;

    assign full    = count_reg == CNT_BITS'(DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = slot_reg[rptr_reg];

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            if (do_pop)
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wptr_reg] <= din;
    end

endmodule

// ===== rtl/core/sawtc_back.sv =====
`include "set_assoc_write_through_cache_defines.svh"

module sawtc_back #(
    parameter int NUM_SETS  = sawtc_pkg::NUM_SETS_DEF,
    parameter int LINE_SIZE = sawtc_pkg::LINE_SIZE_DEF,
    parameter int NUM_WAYS  = sawtc_pkg::NUM_WAYS_DEF,
    parameter int ADDR_BITS = sawtc_pkg::ADDR_BITS_DEF,
    parameter int AGE_BITS  = sawtc_pkg::AGE_BITS_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  sawtc_pkg::op_t  op_head,
    input  logic            op_empty,
    output logic            op_pop,
    output logic            init_done,
    sawtc_rsp_if.source     rsp
);
    import sawtc_pkg::*;

    localparam int OFF_LOG   = $clog2(LINE_SIZE);
    localparam int SET_LOG   = $clog2(NUM_SETS);
    localparam int WAY_LOG   = $clog2(NUM_WAYS);
    localparam int SET_W     = (SET_LOG > 0) ? SET_LOG : 1;
    localparam int WAY_W     = (WAY_LOG > 0) ? WAY_LOG : 1;
    localparam int META_N    = NUM_SETS * NUM_WAYS;
    localparam int META_W    = ($clog2(META_N) > 0) ? $clog2(META_N) : 1;
    localparam int TAG_W     = ADDR_BITS - OFF_LOG - SET_LOG;
    localparam int META_BITS = 1 + TAG_W + AGE_BITS;
    localparam int ROW_W     = ADDR_BITS - OFF_LOG;
    localparam int ROWS      = 1 << ROW_W;
    localparam int LINE_BITS = LINE_SIZE * 8;
    localparam int CLR_N     = (ROWS > META_N) ? ROWS : META_N;
    localparam int CLR_W     = $clog2(CLR_N);
    localparam logic [AGE_BITS-1:0] AGE_MAX = {AGE_BITS{1'b1}};

    // memories
    logic [META_BITS-1:0] meta_mem [META_N];
    logic [LINE_BITS-1:0] line_mem [META_N];
    logic [LINE_BITS-1:0] back_mem [ROWS];

    bk_state_t            state_reg, state_next;
    op_t                  op_reg, op_next;
    logic [WAY_W-1:0]     way_reg, way_next;
    logic                 chk_vld_reg, chk_vld_next;
    logic [WAY_W-1:0]     chk_way_reg, chk_way_next;
    logic                 hit_found_reg, hit_found_next;
    logic [WAY_W-1:0]     hit_way_reg, hit_way_next;
    logic                 inv_found_reg, inv_found_next;
    logic [WAY_W-1:0]     inv_way_reg, inv_way_next;
    logic                 have_reg, have_next;
    logic [AGE_BITS-1:0]  best_reg, best_next;
    logic [WAY_W-1:0]     max_way_reg, max_way_next;
    logic                 use_reg, use_next;
    logic [WAY_W-1:0]     chosen_reg, chosen_next;
    logic [DATA_W-1:0]    acc_data_reg, acc_data_next;
    logic [CNT_W-1:0]     acc_hits_reg, acc_hits_next;
    logic [CLR_W-1:0]     clr_reg, clr_next;
    logic                 out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]    out_data_reg, out_data_next;
    logic [CNT_W-1:0]     out_looks_reg, out_looks_next;
    logic [CNT_W-1:0]     out_hits_reg, out_hits_next;

    logic [META_BITS-1:0] meta_rd_reg;
    logic [LINE_BITS-1:0] line_rd_reg;
    logic [LINE_BITS-1:0] back_rd_reg;

    logic [META_W-1:0]    meta_raddr, meta_waddr, line_raddr, line_waddr;
    logic                 meta_we, line_we, back_we;
    logic [META_BITS-1:0] meta_wdata;
    logic [LINE_BITS-1:0] line_wdata, back_wdata;
    logic [LINE_SIZE-1:0] line_be, back_be;
    logic [ROW_W-1:0]     back_raddr, back_waddr;

    logic [ADDR_BITS-1:0] op_addr;
    logic [OFF_LOG-1:0]   op_off;
    logic [SET_W-1:0]     op_set;
    logic [TAG_W-1:0]     op_tag;
    logic [ROW_W-1:0]     op_row;

    logic                 ent_valid;
    logic [TAG_W-1:0]     ent_tag;
    logic [AGE_BITS-1:0]  ent_age;
    logic [LINE_BITS-1:0] src_row, shifted_row, wr_row;
    logic [DATA_W-1:0]    byte_mask;
    logic [3:0]           lane_be;
    logic [DATA_W-1:0]    rd_bytes;

    function automatic logic [META_W-1:0] meta_idx(input logic [SET_W-1:0] s,
                                                  input logic [WAY_W-1:0] w);
        meta_idx = META_W'((64'(s) << WAY_LOG) | 64'(w));
    endfunction

    // address decode of the current lookup
    assign op_addr = ADDR_BITS'(op_reg.addr);
    assign op_off  = OFF_LOG'(op_addr);
    assign op_set  = SET_W'(op_addr >> OFF_LOG) & SET_W'(NUM_SETS - 1);
    assign op_tag  = TAG_W'(op_addr >> (OFF_LOG + SET_LOG));
    assign op_row  = ROW_W'(op_addr >> OFF_LOG);

    assign {ent_valid, ent_tag, ent_age} = meta_rd_reg;

    // byte lanes of the access
    always_comb
    begin
        case (op_reg.nbytes)
            3'd0:    begin byte_mask = 32'h0000_0000; lane_be = 4'b0000; end
            3'd1:    begin byte_mask = 32'h0000_00FF; lane_be = 4'b0001; end
            3'd2:    begin byte_mask = 32'h0000_FFFF; lane_be = 4'b0011; end
            3'd3:    begin byte_mask = 32'h00FF_FFFF; lane_be = 4'b0111; end
            default: begin byte_mask = 32'hFFFF_FFFF; lane_be = 4'b1111; end
        endcase
    end

    assign src_row     = hit_found_reg ? line_rd_reg : back_rd_reg;
    assign shifted_row = src_row >> {op_off, 3'b000};
    assign rd_bytes    = DATA_W'(shifted_row) & byte_mask;
    assign wr_row      = LINE_BITS'(op_reg.wdata) << {op_off, 3'b000};

    assign init_done     = state_reg != BK_CLEAR;
    assign rsp.valid     = out_valid_reg;
    assign rsp.read_data = out_data_reg;
    assign rsp.lookups   = out_looks_reg;
    assign rsp.hit_count = out_hits_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        way_next       = way_reg;
        chk_vld_next   = 1'b0;
        chk_way_next   = chk_way_reg;
        hit_found_next = hit_found_reg;
        hit_way_next   = hit_way_reg;
        inv_found_next = inv_found_reg;
        inv_way_next   = inv_way_reg;
        have_next      = have_reg;
        best_next      = best_reg;
        max_way_next   = max_way_reg;
        use_next       = use_reg;
        chosen_next    = chosen_reg;
        acc_data_next  = acc_data_reg;
        acc_hits_next  = acc_hits_reg;
        clr_next       = clr_reg;
        out_valid_next = out_valid_reg && !rsp.ready;
        out_data_next  = out_data_reg;
        out_looks_next = out_looks_reg;
        out_hits_next  = out_hits_reg;
        op_pop         = 1'b0;
        meta_raddr     = meta_idx(op_set, way_reg);
        meta_we        = 1'b0;
        meta_waddr     = meta_idx(op_set, chk_way_reg);
        meta_wdata     = meta_rd_reg;
        line_raddr     = meta_idx(op_set, chosen_reg);
        line_we        = 1'b0;
        line_waddr     = meta_idx(op_set, chosen_reg);
        line_wdata     = wr_row;
        line_be        = LINE_SIZE'(lane_be) << op_off;
        back_raddr     = op_row;
        back_we        = 1'b0;
        back_waddr     = op_row;
        back_wdata     = wr_row;
        back_be        = LINE_SIZE'(lane_be) << op_off;

        // tag and age scan of one way per cycle
        if ((state_reg == BK_SCAN || state_reg == BK_SCAN_TAIL) && chk_vld_reg)
        begin
            if (ent_valid && ent_tag == op_tag && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_way_next   = chk_way_reg;
            end
            if (!ent_valid && !inv_found_reg)
            begin
                inv_found_next = 1'b1;
                inv_way_next   = chk_way_reg;
            end
            if (ent_valid && (!have_reg || ent_age > best_reg))
            begin
                have_next    = 1'b1;
                best_next    = ent_age;
                max_way_next = chk_way_reg;
            end
        end

        // age update of one way per cycle
        if ((state_reg == BK_UPDATE || state_reg == BK_UPD_TAIL) && chk_vld_reg)
        begin
            meta_we = 1'b1;
            if (use_reg && chk_way_reg == chosen_reg)
                meta_wdata = {ent_valid || !op_reg.wr, op_tag, {AGE_BITS{1'b0}}};
            else if (ent_valid && ent_age != AGE_MAX)
                meta_wdata = {ent_valid, ent_tag, AGE_BITS'(ent_age + 1'b1)};
        end

        case (state_reg)
            BK_CLEAR:
            begin
                meta_waddr = META_W'(clr_reg);
                meta_wdata = '0;
                meta_we    = 64'(clr_reg) < 64'(META_N);
                back_waddr = ROW_W'(clr_reg);
                back_wdata = '0;
                back_be    = '1;
                back_we    = 64'(clr_reg) < 64'(ROWS);
                clr_next   = clr_reg + 1'b1;
                if (clr_reg == CLR_W'(CLR_N - 1))
                    state_next = BK_IDLE;
            end
            BK_IDLE:
            begin
                if (!op_empty)
                begin
                    op_pop         = 1'b1;
                    op_next        = op_head;
                    way_next       = '0;
                    hit_found_next = 1'b0;
                    inv_found_next = 1'b0;
                    have_next      = 1'b0;
                    state_next     = BK_SCAN;
                end
            end
            BK_SCAN:
            begin
                chk_vld_next = 1'b1;
                chk_way_next = way_reg;
                way_next     = way_reg + 1'b1;
                if (way_reg == WAY_W'(NUM_WAYS - 1))
                    state_next = BK_SCAN_TAIL;
            end
            BK_SCAN_TAIL:
            begin
                state_next = BK_DECIDE;
            end
            BK_DECIDE:
            begin
                if (op_reg.wr)
                begin
                    use_next    = hit_found_reg;
                    chosen_next = hit_way_reg;
                end
                else
                begin
                    use_next = 1'b1;
                    if (hit_found_reg)
                        chosen_next = hit_way_reg;
                    else if (inv_found_reg)
                        chosen_next = inv_way_reg;
                    else
                        chosen_next = max_way_reg;
                end
                state_next = BK_DATA_RD;
            end
            BK_DATA_RD:
            begin
                state_next = BK_DATA_WR;
            end
            BK_DATA_WR:
            begin
                if (op_reg.wr)
                begin
                    back_we = 1'b1;
                    line_we = hit_found_reg;
                end
                else
                begin
                    acc_data_next = acc_data_reg | (rd_bytes << {op_reg.lane, 3'b000});
                    if (!hit_found_reg)
                    begin
                        line_we    = 1'b1;
                        line_wdata = back_rd_reg;
                        line_be    = '1;
                    end
                end
                acc_hits_next = acc_hits_reg + CNT_W'(hit_found_reg);
                way_next      = '0;
                state_next    = BK_UPDATE;
            end
            BK_UPDATE:
            begin
                chk_vld_next = 1'b1;
                chk_way_next = way_reg;
                way_next     = way_reg + 1'b1;
                if (way_reg == WAY_W'(NUM_WAYS - 1))
                    state_next = BK_UPD_TAIL;
            end
            BK_UPD_TAIL:
            begin
                state_next = op_reg.last ? BK_FINISH : BK_IDLE;
            end
            BK_FINISH:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = op_reg.wr ? '0 : acc_data_reg;
                    out_looks_next = op_reg.lookups;
                    out_hits_next  = acc_hits_reg;
                    acc_data_next  = '0;
                    acc_hits_next  = '0;
                    state_next     = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_CLEAR;
            clr_reg       <= '0;
            chk_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            acc_data_reg  <= '0;
            acc_hits_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            chk_vld_reg   <= chk_vld_next;
            out_valid_reg <= out_valid_next;
            acc_data_reg  <= acc_data_next;
            acc_hits_reg  <= acc_hits_next;
        end
    end

    // lookup working registers
    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        way_reg       <= way_next;
        chk_way_reg   <= chk_way_next;
        hit_found_reg <= hit_found_next;
        hit_way_reg   <= hit_way_next;
        inv_found_reg <= inv_found_next;
        inv_way_reg   <= inv_way_next;
        have_reg      <= have_next;
        best_reg      <= best_next;
        max_way_reg   <= max_way_next;
        use_reg       <= use_next;
        chosen_reg    <= chosen_next;
        out_data_reg  <= out_data_next;
        out_looks_reg <= out_looks_next;
        out_hits_reg  <= out_hits_next;
    end

    // way state memory
    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_waddr] <= meta_wdata;
        meta_rd_reg <= meta_mem[meta_raddr];
    end

    // line data memory
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LINE_SIZE; i++)
        begin
            if (line_we && line_be[i])
                line_mem[line_waddr][i*8 +: 8] <= line_wdata[i*8 +: 8];
        end
        line_rd_reg <= line_mem[line_raddr];
    end

    // backing memory
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LINE_SIZE; i++)
        begin
            if (back_we && back_be[i])
                back_mem[back_waddr][i*8 +: 8] <= back_wdata[i*8 +: 8];
        end
        back_rd_reg <= back_mem[back_raddr];
    end

    `SAWTC_ASSERT_NOW(a_no_pop_in_clear, state_reg == BK_CLEAR, !op_pop,
        "lookup taken during clearing pass")
    `SAWTC_ASSERT_NOW(a_hits_bounded, state_reg == BK_FINISH,
        acc_hits_reg <= op_reg.lookups, "more hits than lookups")
    `SAWTC_ASSERT_NEXT(a_finish_loads,
        state_reg == BK_FINISH && (!out_valid_reg || rsp.ready),
        out_valid_reg && state_reg == BK_IDLE, "result not loaded at finish")

endmodule

// ===== rtl/core/set_assoc_write_through_cache.sv =====
// channel | dir | payload                                   | handshake
// req     | in  | req_type, address, length, write_data     | valid/ready
// rsp     | out | read_data, lookups, hit_count             | valid/ready
//
// each lookup steps one way per cycle through the way state memory, scanning
// it once and then rewriting it with the new ages.
// a request takes 1 lookup, or one per byte (length capped at 4) when it
// crosses a line. after reset a clearing pass zeroes the way state memory
// and the backing memory; requests wait until it ends.
// a result waits in an output register; the front keeps taking requests
// while the lookup queue has room.
module set_assoc_write_through_cache #(
    parameter int NUM_SETS  = sawtc_pkg::NUM_SETS_DEF,
    parameter int LINE_SIZE = sawtc_pkg::LINE_SIZE_DEF,
    parameter int NUM_WAYS  = sawtc_pkg::NUM_WAYS_DEF,
    parameter int ADDR_BITS = sawtc_pkg::ADDR_BITS_DEF,
    parameter int AGE_BITS  = sawtc_pkg::AGE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    sawtc_req_if.sink    req,
    sawtc_rsp_if.source  rsp
);
    import sawtc_pkg::*;

    op_t   push_op, head_op;
    logic  op_push, op_full, op_pop, op_empty, init_done;

    sawtc_front #(
        .ADDR_BITS (ADDR_BITS),
        .LINE_SIZE (LINE_SIZE)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .init_done (init_done),
        .op        (push_op),
        .op_push   (op_push),
        .op_full   (op_full)
    );

    sawtc_op_fifo #(
        .DEPTH (OPQ_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (op_push),
        .din   (push_op),
        .full  (op_full),
        .pop   (op_pop),
        .dout  (head_op),
        .empty (op_empty)
    );

    sawtc_back #(
        .NUM_SETS  (NUM_SETS),
        .LINE_SIZE (LINE_SIZE),
        .NUM_WAYS  (NUM_WAYS),
        .ADDR_BITS (ADDR_BITS),
        .AGE_BITS  (AGE_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .op_head   (head_op),
        .op_empty  (op_empty),
        .op_pop    (op_pop),
        .init_done (init_done),
        .rsp       (rsp)
    );

endmodule

// ===== tb/tb_set_assoc_write_through_cache.sv =====
`timescale 1ns / 1ps

// expected-response tracker with its own copy of the cache and backing memory
class cache_scoreboard;
    typedef struct {
        bit [31:0] read_data;
        bit [2:0]  lookups;
        bit [2:0]  hit_count;
    } cache_rsp_t;

    cache_rsp_t pending[$];
    int         errors;

    bit         way_ok[1024];
    bit [10:0]  way_tg[1024];
    bit [15:0]  way_lru[1024];
    bit [7:0]   line_mem[65536];
    bit [7:0]   main_mem[1048576];

    // bump every other valid way of a set, saturating
    function void age_set(int unsigned base, int keep);
        for (int w = 0; w < 128; w++)
        begin
            if (w != keep && way_ok[base + w] && way_lru[base + w] != 16'hFFFF)
                way_lru[base + w]++;
        end
    endfunction

    // one line lookup of n bytes within a single line, returns 1 on hit
    function int line_lookup(bit wr, bit [19:0] a, int n, bit [31:0] wd,
                             output bit [31:0] rd);
        int unsigned set_idx;
        int unsigned base;
        bit [10:0]   tg;
        int unsigned off;
        int          way;
        int          hit;
        bit [15:0]   best;
        bit          have;
        int unsigned slot;
        set_idx = (a >> 6) & 7;
        tg      = 11'(a >> 9);
        off     = a & 63;
        base    = set_idx * 128;
        way     = -1;
        rd      = 0;
        for (int w = 0; w < 128; w++)
        begin
            if (way_ok[base + w] && way_tg[base + w] == tg)
            begin
                way = w;
                break;
            end
        end
        hit = (way >= 0);
        if (wr == sawtc_pkg::REQ_READ)
        begin
            if (!hit)
            begin
                best = 0;
                have = 0;
                for (int w = 0; w < 128; w++)
                begin
                    if (!way_ok[base + w])
                    begin
                        way = w;
                        break;
                    end
                    if (!have || way_lru[base + w] > best)
                    begin
                        best = way_lru[base + w];
                        way  = w;
                        have = 1;
                    end
                end
                // refill the chosen way from the line base
                for (int i = 0; i < 64; i++)
                    line_mem[(base + way) * 64 + i] = main_mem[{a[19:6], 6'd0} + i];
            end
            slot          = base + way;
            way_ok[slot]  = 1;
            way_tg[slot]  = tg;
            way_lru[slot] = 0;
            age_set(base, way);
            for (int i = 0; i < n; i++)
                rd |= 32'(line_mem[slot * 64 + off + i]) << (8 * i);
        end
        else
        begin
            age_set(base, way);
            if (hit)
            begin
                slot          = base + way;
                way_lru[slot] = 0;
                for (int i = 0; i < n; i++)
                    line_mem[slot * 64 + off + i] = wd[8 * i +: 8];
            end
            for (int i = 0; i < n; i++)
                main_mem[20'(a + i)] = wd[8 * i +: 8];
        end
        return hit;
    endfunction

    // predict the response of an accepted request
    function void note_request(bit rt, bit [19:0] a, bit [2:0] len_in, bit [31:0] wd);
        cache_rsp_t r;
        int         n;
        bit [31:0]  b;
        int         hits;
        n    = (len_in > 4) ? 4 : len_in;
        hits = 0;
        r.read_data = 0;
        if ((a & 63) + n > 64)
        begin
            r.lookups = 3'(n);
            for (int i = 0; i < n; i++)
            begin
                hits += line_lookup(rt, 20'(a + i), 1, {24'd0, wd[8 * i +: 8]}, b);
                r.read_data |= (b & 32'hFF) << (8 * i);
            end
        end
        else
        begin
            r.lookups = 3'd1;
            hits = line_lookup(rt, a, n, wd, r.read_data);
        end
        if (rt == sawtc_pkg::REQ_WRITE)
            r.read_data = 0;
        r.hit_count = 3'(hits);
        pending.push_back(r);
    endfunction

    // compare a response with the oldest prediction
    function void check_response(bit [31:0] rd, bit [2:0] lk, bit [2:0] hc);
        cache_rsp_t e;
        if (pending.size() == 0)
        begin
            $error("unexpected response read_data=%h lookups=%0d hit_count=%0d",
                   rd, lk, hc);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (rd !== e.read_data)
        begin
            $error("read_data expected %h actual %h", e.read_data, rd);
            errors++;
        end
        if (lk !== e.lookups)
        begin
            $error("lookups expected %0d actual %0d", e.lookups, lk);
            errors++;
        end
        if (hc !== e.hit_count)
        begin
            $error("hit_count expected %0d actual %0d", e.hit_count, hc);
            errors++;
        end
    endfunction
endclass

module tb_set_assoc_write_through_cache;
    import sawtc_pkg::*;

    logic clk;
    logic rst_n;
    bit   quiet;
    int   stall_left;
    bit [10:0] hot_tags[12];

    cache_scoreboard sb;

    sawtc_req_if req ();
    sawtc_rsp_if rsp ();

    set_assoc_write_through_cache u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    always #10 clk = ~clk;

    // note accepted requests and check accepted responses
    always @(posedge clk)
    begin
        if (rst_n && req.valid && req.ready)
            sb.note_request(req.req_type, req.address, req.length, req.write_data);
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_response(rsp.read_data, rsp.lookups, rsp.hit_count);
    end

    // response back-pressure in random bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            rsp.ready  <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(1, 6) - 1;
            rsp.ready  <= 1'b0;
        end
        else
            rsp.ready <= 1'b1;
    end

    // present one request and hold it until taken
    task automatic send_request(bit rt, bit [19:0] a, bit [2:0] len, bit [31:0] wd);
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        req.valid      <= 1'b1;
        req.req_type   <= rt;
        req.address    <= a;
        req.length     <= len;
        req.write_data <= wd;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
    endtask

    // random length, mostly legal sizes
    function automatic bit [2:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 3'd0;
        if (r == 1)
            return 3'($urandom_range(5, 7));
        return 3'($urandom_range(1, 4));
    endfunction

    // address in a few hot lines, often near a line end
    function automatic bit [19:0] hot_addr();
        bit [5:0] off;
        off = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(60, 63)) : 6'($urandom);
        return {hot_tags[$urandom_range(0, 11)], 3'($urandom_range(0, 7)), off};
    endfunction

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        bit rt;
        sb             = new();
        clk            = 1'b0;
        rst_n          = 1'b0;
        quiet          = 1'b0;
        stall_left     = 0;
        req.valid      = 1'b0;
        req.req_type   = REQ_READ;
        req.address    = '0;
        req.length     = 3'd1;
        req.write_data = '0;
        rsp.ready      = 1'b1;
        foreach (hot_tags[i])
            hot_tags[i] = 11'($urandom);
        hot_tags[0] = 11'h000;
        hot_tags[1] = 11'h7FF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: cleared memory, extremes, odd lengths, line crossings, wrap
        send_request(REQ_READ,  20'h00000, 3'd4, 32'h0);
        send_request(REQ_WRITE, 20'h00000, 3'd4, 32'hFFFFFFFF);
        send_request(REQ_READ,  20'h00000, 3'd4, 32'h0);
        send_request(REQ_WRITE, 20'h00000, 3'd2, 32'h00000000);
        send_request(REQ_READ,  20'h00000, 3'd4, 32'hFFFFFFFF);
        send_request(REQ_WRITE, 20'hFFFFC, 3'd4, 32'hA5C3_5A3C);
        send_request(REQ_READ,  20'hFFFFC, 3'd4, 32'h0);
        send_request(REQ_WRITE, 20'hFFFFE, 3'd4, 32'h1234_5678);
        send_request(REQ_READ,  20'hFFFFF, 3'd4, 32'h0);
        send_request(REQ_READ,  20'h00000, 3'd1, 32'h0);
        send_request(REQ_WRITE, 20'h0003E, 3'd3, 32'hDEAD_BEEF);
        send_request(REQ_READ,  20'h0003D, 3'd4, 32'h0);
        send_request(REQ_READ,  20'h0003E, 3'd3, 32'h0);
        send_request(REQ_READ,  20'h00100, 3'd0, 32'h0);
        send_request(REQ_WRITE, 20'h00100, 3'd0, 32'hFFFFFFFF);
        send_request(REQ_WRITE, 20'h00200, 3'd7, 32'hCAFE_F00D);
        send_request(REQ_READ,  20'h00200, 3'd5, 32'h0);
        send_request(REQ_READ,  20'h00200, 3'd6, 32'h0);
        send_request(REQ_WRITE, 20'h7FFC0, 3'd1, 32'h0000_0081);
        send_request(REQ_READ,  20'h7FFC0, 3'd1, 32'h0);
        send_request(REQ_READ,  20'h80000, 3'd2, 32'h0);

        // hold off until every response is back
        req.valid <= 1'b0;
        wait_drained();

        // fill one set past its ways so the oldest way gets evicted
        for (int i = 0; i < 140; i++)
        begin
            if (i % 16 == 5)
                send_request(REQ_READ, {11'd3, 3'd5, 6'd0}, 3'd4, 32'h0);
            else
                send_request(REQ_READ, {11'(i * 13 + 40), 3'd5, 6'($urandom)},
                             pick_len(), 32'h0);
        end
        for (int i = 0; i < 20; i++)
            send_request($urandom_range(0, 1), {11'($urandom_range(0, 60) * 13 + 40),
                         3'd5, 6'($urandom)}, pick_len(), $urandom);

        // random traffic, mostly on hot lines
        for (int i = 0; i < 670; i++)
        begin
            if (i == 570)
                quiet = 1'b1;
            rt = $urandom_range(0, 2) == 0;
            if ($urandom_range(0, 5) == 0)
                send_request(rt, 20'($urandom), pick_len(), $urandom);
            else
                send_request(rt, hot_addr(), pick_len(), $urandom);
        end
        req.valid <= 1'b0;

        wait_drained();
        repeat (1200) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // overall time limit
    initial
    begin
        #100ms;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule
